[hdl/llc_slice_set_histogram_unit_macros.svh]
// Assertion helpers for the histogram unit.
`ifndef LLC_SLICE_SET_HISTOGRAM_UNIT_MACROS_SVH
`define LLC_SLICE_SET_HISTOGRAM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLCSH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llcsh assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LLCSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llcsh assertion failed");

`endif

[hdl/llcsh_pkg.sv]
package llcsh_pkg;

  localparam int unsigned SET_COUNT   = 2048;
  localparam int unsigned SLICE_COUNT = 8;
  localparam int unsigned SET_W       = 11;
  localparam int unsigned SLICE_W     = 3;
  localparam int unsigned MEM_DEPTH   = SET_COUNT * SLICE_COUNT;
  localparam int unsigned MEM_AW      = SET_W + SLICE_W;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned VALUE_W     = 32;

  localparam logic [ADDR_W-1:0] HASH_MASK0 = 48'h001B_5F57_5440;
  localparam logic [ADDR_W-1:0] HASH_MASK1 = 48'h002E_B5FA_A880;
  localparam logic [ADDR_W-1:0] HASH_MASK2 = 48'h003C_CCC9_3100;
  localparam int unsigned SET_SHIFT = 6;
  localparam int unsigned SET_TOP   = 17;
  localparam logic [3:0] GROUP_BITS_MAX = 4'd11;

  // Counting modes.
  localparam logic [1:0] MODE_SLICE = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_WATCH = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_COUNT_MODE  = 2'd0;
  localparam logic [1:0] REG_GROUP_BITS  = 2'd1;
  localparam logic [1:0] REG_WATCHED_SET = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] phys_addr;
    logic [SET_W-1:0]  read_set;
    logic [SLICE_W-1:0] read_slice;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] count_value;
    logic [SET_W-1:0]   set_index;
    logic [SLICE_W-1:0] slice_index;
    logic               counted;
  } out_item_t;

  // A classified request as it waits between front and back.
  typedef struct packed {
    logic               is_read;
    logic               bump;
    logic [SET_W-1:0]   row;
    logic [SLICE_W-1:0] slice;
    logic [SLICE_W-1:0] mem_col;
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

endpackage

[hdl/llcsh_front.sv]
module llcsh_front (
  input  llcsh_pkg::in_item_t in_item,
  input  logic [1:0]          count_mode,
  input  logic [3:0]          group_bits,
  input  logic [10:0]         watched_set,
  output llcsh_pkg::op_t      op
);

  logic [llcsh_pkg::SLICE_W-1:0] slice;
  logic [llcsh_pkg::SET_W-1:0]   set;
  logic [3:0]                    g;
  logic [3:0]                    low_bits;
  logic [llcsh_pkg::SET_W-1:0]   low_mask;
  logic [llcsh_pkg::SET_W-1:0]   group_row;
  logic                          match;

  always_comb begin
    slice[0] = ^(in_item.phys_addr & llcsh_pkg::HASH_MASK0);
    slice[1] = ^(in_item.phys_addr & llcsh_pkg::HASH_MASK1);
    slice[2] = ^(in_item.phys_addr & llcsh_pkg::HASH_MASK2);
    set      = in_item.phys_addr[llcsh_pkg::SET_TOP-1:llcsh_pkg::SET_SHIFT];

    // The group index is the top g bits of the set; the rest must match.
    g         = (group_bits > llcsh_pkg::GROUP_BITS_MAX) ? llcsh_pkg::GROUP_BITS_MAX
                                                         : group_bits;
    low_bits  = llcsh_pkg::GROUP_BITS_MAX - g;
    low_mask  = {llcsh_pkg::SET_W{1'b1}} >> g;
    group_row = set >> low_bits;
    match     = ((set & low_mask) == watched_set);

    op = '0;
    if (in_item.func) begin
      op.is_read = 1'b1;
      op.row     = in_item.read_set;
      op.slice   = in_item.read_slice;
      op.mem_col = in_item.read_slice;
    end else begin
      op.slice = slice;
      op.row   = set;
      unique case (count_mode)
        llcsh_pkg::MODE_SLICE: begin
          op.bump    = 1'b1;
          op.mem_col = slice;
        end
        llcsh_pkg::MODE_SET: begin
          op.bump = 1'b1;
        end
        llcsh_pkg::MODE_WATCH: begin
          op.row  = group_row;
          op.bump = match;
        end
        default: begin
          op.bump = 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/llcsh_queue.sv]
module llcsh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  llcsh_pkg::op_t push_op,
  input  logic           pop,
  output llcsh_pkg::op_t head_op,
  output logic           full,
  output logic           empty
);

  llcsh_pkg::op_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  always_comb begin
    full       = (count_r == 2'd2);
    empty      = (count_r == 2'd0);
    head_op    = entry_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[hdl/llcsh_back.sv]
module llcsh_back #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  llcsh_pkg::op_t        q_head,
  output logic                  q_pop,
  output logic                  clearing,
  input  logic                  out_pop,
  output logic                  out_valid,
  output llcsh_pkg::out_item_t  out_item
);

  logic [COUNTER_WIDTH-1:0] mem [llcsh_pkg::MEM_DEPTH];

  llcsh_pkg::back_state_t   state_r, state_nxt;
  logic [llcsh_pkg::MEM_AW-1:0] clr_addr_r, clr_addr_nxt;
  llcsh_pkg::op_t           op_r;
  logic [COUNTER_WIDTH-1:0] rd_data_r;
  logic                     out_valid_r, out_valid_nxt;
  llcsh_pkg::out_item_t     out_item_r, out_item_nxt;

  logic                         slot_free;
  logic                         rd_en;
  logic [llcsh_pkg::MEM_AW-1:0] rd_addr;
  logic                         we;
  logic [llcsh_pkg::MEM_AW-1:0] waddr;
  logic [COUNTER_WIDTH-1:0]     wdata;
  logic                         load;
  logic [63:0]                  wide_value;
  logic [llcsh_pkg::VALUE_W-1:0] sat_value;

  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llcsh_pkg::ST_CLEAR: begin
        if (clr_addr_r == {llcsh_pkg::MEM_AW{1'b1}}) state_nxt = llcsh_pkg::ST_IDLE;
      end
      llcsh_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = llcsh_pkg::ST_UPDATE;
      end
      llcsh_pkg::ST_UPDATE: begin
        if (slot_free) state_nxt = llcsh_pkg::ST_IDLE;
      end
      default: state_nxt = llcsh_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing     = (state_r == llcsh_pkg::ST_CLEAR);
    q_pop        = (state_r == llcsh_pkg::ST_IDLE) && q_valid;
    rd_en        = q_pop;
    rd_addr      = {q_head.row, q_head.mem_col};
    load         = (state_r == llcsh_pkg::ST_UPDATE) && slot_free;
    clr_addr_nxt = clearing ? clr_addr_r + 1'b1 : clr_addr_r;

    wide_value = 64'(rd_data_r);
    sat_value  = (wide_value > 64'h0000_0000_FFFF_FFFF) ? {llcsh_pkg::VALUE_W{1'b1}}
                                                       : wide_value[llcsh_pkg::VALUE_W-1:0];

    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = load && (op_r.is_read || op_r.bump);
      waddr = {op_r.row, op_r.mem_col};
      if (op_r.is_read || rd_data_r == {COUNTER_WIDTH{1'b1}}) begin
        wdata = op_r.is_read ? '0 : rd_data_r;
      end else begin
        wdata = rd_data_r + COUNTER_WIDTH'(1);
      end
    end

    out_item_nxt             = out_item_r;
    out_item_nxt.count_value = op_r.is_read ? sat_value : '0;
    out_item_nxt.set_index   = op_r.row;
    out_item_nxt.slice_index = op_r.slice;
    out_item_nxt.counted     = op_r.bump;

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_valid = out_valid_r;
    out_item  = out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llcsh_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_head;
    end
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[hdl/llc_slice_set_histogram_unit.sv]
// Channel        | Direction | Handshake          | Payload
// in_            | request   | in_push / in_full  | in_item   (llcsh_pkg::in_item_t)
// out_           | result    | out_empty / out_pop| out_item  (llcsh_pkg::out_item_t)
// cfg_           | registers | APB psel/penable   | pwdata / prdata, 32 bits
//
// In the counter engine each request first reads the counter memory, then writes
// it back and loads the result register once that register is free.
// After reset a clearing pass writes zero to all 16384 counters, one a cycle;
// in_full stays high throughout the pass, while configuration is taken.
// A two-entry queue lets requests arrive while the engine waits on out_pop.

`include "llc_slice_set_histogram_unit_macros.svh"

module llc_slice_set_histogram_unit #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  llcsh_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output llcsh_pkg::out_item_t out_item,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  // Configuration registers. The user must change them only while the block is
  // idle; the block does not enforce this. The front end reads them directly.
  logic [1:0]  count_mode_r,  count_mode_nxt;
  logic [3:0]  group_bits_r,  group_bits_nxt;
  logic [10:0] watched_set_r, watched_set_nxt;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  // Between the stages.
  llcsh_pkg::op_t front_op;
  llcsh_pkg::op_t q_head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic           clearing;
  logic           out_valid;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[3:2];

  always_comb begin
    count_mode_nxt  = count_mode_r;
    group_bits_nxt  = group_bits_r;
    watched_set_nxt = watched_set_r;
    if (cfg_write) begin
      unique case (cfg_index)
        llcsh_pkg::REG_COUNT_MODE:  count_mode_nxt  = cfg_pwdata[1:0];
        llcsh_pkg::REG_GROUP_BITS:  group_bits_nxt  = cfg_pwdata[3:0];
        llcsh_pkg::REG_WATCHED_SET: watched_set_nxt = cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register reads; the unused address returns zero.
  always_comb begin
    unique case (cfg_index)
      llcsh_pkg::REG_COUNT_MODE:  cfg_prdata = 32'(count_mode_r);
      llcsh_pkg::REG_GROUP_BITS:  cfg_prdata = 32'(group_bits_r);
      llcsh_pkg::REG_WATCHED_SET: cfg_prdata = 32'(watched_set_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_mode_r  <= '0;
      group_bits_r  <= '0;
      watched_set_r <= '0;
    end else begin
      count_mode_r  <= count_mode_nxt;
      group_bits_r  <= group_bits_nxt;
      watched_set_r <= watched_set_nxt;
    end
  end

  // The front end hashes the address into a slice, picks the counter row and
  // column for the current mode, and decides whether the sample counts at all.
  llcsh_front u_front (
    .in_item     (in_item),
    .count_mode  (count_mode_r),
    .group_bits  (group_bits_r),
    .watched_set (watched_set_r),
    .op          (front_op)
  );

  // Requests are refused while the queue is full or the counters are still
  // being cleared after reset.
  assign in_full = q_full || clearing;
  assign q_push  = in_push && !in_full;

  llcsh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (front_op),
    .pop     (q_pop),
    .head_op (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back end owns the counter memory and performs the read-modify-write,
  // saturating on increment and clearing on read.
  llcsh_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_empty = !out_valid;

  // The input side must be closed for the whole clearing pass.
  `LLCSH_ASSERT_SAME(a_full_while_clearing, clk, rst_n, clearing, in_full)
  // The queue is never written while it is full.
  `LLCSH_ASSERT_SAME(a_no_queue_overflow, clk, rst_n, q_full, !q_push)
  // A counted sample never carries a read value.
  `LLCSH_ASSERT_SAME(a_counted_has_no_value, clk, rst_n, !out_empty && out_item.counted,
                     out_item.count_value == '0)
  // No request leaves the queue during the clearing pass.
  `LLCSH_ASSERT_SAME(a_no_pop_while_clearing, clk, rst_n, clearing, !q_pop)

endmodule
